// ----- rtl/mfa_pkg.sv -----
// ----------------------------------------------------------------------------
// mfa_pkg
// Shared constants, sequencer states and a helper for the arena allocator.
// ----------------------------------------------------------------------------
package mfa_pkg;

  localparam int ARENAS_DEF      = 8;
  localparam int ARENA_WORDS_DEF = 4096;

  localparam int MODE_W   = 1;
  localparam int BYTES_W  = 15;
  localparam int ARENA_W  = 3;
  localparam int OFFSET_W = 12;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR,
    ST_MRG,
    ST_MW,
    ST_SPLIT,
    ST_HDRW,
    ST_PAD,
    ST_F1,
    ST_F2,
    ST_DONE
  } state_t;

  // start arena modulo the arena count; narrow value, repeated subtract
  function automatic logic [ARENA_W-1:0] arena_mod(input logic [ARENA_W-1:0] s,
                                                   input int n);
    int r;
    r = int'(s);
    for (int k = 0; k < 8; k++) begin
      if (r >= n) begin
        r = r - n;
      end
    end
    return ARENA_W'(r);
  endfunction

endpackage

// ----- rtl/mfa_ifs.sv -----
// ----------------------------------------------------------------------------
// mfa_ifs
// Request and response channels of the arena allocator.
// ----------------------------------------------------------------------------
interface mfa_req_if;
  logic                             valid;
  logic                             ready;
  logic [mfa_pkg::MODE_W-1:0]       mode;
  logic [mfa_pkg::BYTES_W-1:0]      request_bytes;
  logic [mfa_pkg::ARENA_W-1:0]      start_arena;
  logic [mfa_pkg::ARENA_W-1:0]      free_arena;
  logic [mfa_pkg::OFFSET_W-1:0]     free_offset;

  modport source (output valid, mode, request_bytes, start_arena, free_arena,
                  free_offset, input ready);
  modport sink   (input valid, mode, request_bytes, start_arena, free_arena,
                  free_offset, output ready);
endinterface

interface mfa_rsp_if;
  logic                             valid;
  logic                             ready;
  logic                             ok;
  logic [mfa_pkg::ARENA_W-1:0]      result_arena;
  logic [mfa_pkg::OFFSET_W-1:0]     result_offset;

  modport source (output valid, ok, result_arena, result_offset, input ready);
  modport sink   (input valid, ok, result_arena, result_offset, output ready);
endinterface

// ----- rtl/mfa_heap_ram.sv -----
// ----------------------------------------------------------------------------
// mfa_heap_ram
// Heap word store: one write, one registered read; word 0 of each arena
// reads as a single free block until first written.
// ----------------------------------------------------------------------------
module mfa_heap_ram #(
  parameter int ARENAS      = mfa_pkg::ARENAS_DEF,
  parameter int ARENA_WORDS = mfa_pkg::ARENA_WORDS_DEF,
  parameter int AB          = (ARENAS > 1) ? $clog2(ARENAS) : 1,
  parameter int WB          = $clog2(ARENA_WORDS),
  parameter int DW          = WB + 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [AB-1:0]        wr_arena,
  input  logic [WB-1:0]        wr_word,
  input  logic [DW-1:0]        wr_data,
  input  logic                 rd_en,
  input  logic [AB-1:0]        rd_arena,
  input  logic [WB-1:0]        rd_word,
  output logic [DW-1:0]        rd_data
);

  localparam int DEPTH = (1 << AB) << WB;
  localparam logic [DW-1:0] INIT_HDR = DW'(-(ARENA_WORDS - 1));

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] mem_q;
  logic [ARENAS-1:0] w0_valid;
  logic          rd_zero;
  logic [AB-1:0] rd_arena_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{wr_arena, wr_word}] <= wr_data;
    end
    if (rd_en) begin
      mem_q      <= mem[{rd_arena, rd_word}];
      rd_zero    <= (rd_word == '0);
      rd_arena_q <= rd_arena;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      w0_valid <= '0;
    end else if (wr_en && wr_word == '0) begin
      w0_valid[wr_arena] <= 1'b1;
    end
  end

  assign rd_data = (rd_zero && !w0_valid[rd_arena_q]) ? INIT_HDR : mem_q;

endmodule

// ----- rtl/multi_arena_first_fit_allocator_top.sv -----
// ----------------------------------------------------------------------------
// multi_arena_first_fit_allocator_top
// First-fit word allocator over several arenas with an implicit free list.
// ----------------------------------------------------------------------------
// One request is served at a time. An allocate walks used block headers one per
// cycle through the single heap RAM read port. A free block is merged with
// each free neighbour that follows it, up to the header that ends the run,
// and the merged header is written back; the walk then moves on, to the next
// arena when this one is exhausted. The chosen block then goes through the
// split, the header and, where its payload would be misaligned, the pad. Cost
// rises with fragmentation, and a full miss walks every arena. A new request
// is taken while the previous response still waits to be collected. Word 0 of
// every arena reads as one free block after reset without any clearing pass.
module multi_arena_first_fit_allocator_top #(
  parameter int ARENAS      = mfa_pkg::ARENAS_DEF,
  parameter int ARENA_WORDS = mfa_pkg::ARENA_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  mfa_req_if.sink     req,
  mfa_rsp_if.source   rsp
);

  localparam int AB = (ARENAS > 1) ? $clog2(ARENAS) : 1;
  localparam int WB = $clog2(ARENA_WORDS);
  localparam int DW = WB + 1;
  localparam int KW = (WB + 3 > 16) ? WB + 3 : 16;
  localparam logic signed [KW-1:0] LAST = KW'(ARENA_WORDS - 2);
  localparam logic signed [KW-1:0] ONE  = KW'(1);

  mfa_pkg::state_t state, state_next;

  logic                 align_phase;
  logic                 rsp_valid;
  logic                 rsp_ok;
  logic [2:0]           rsp_arena;
  logic [11:0]          rsp_offset;

  logic [AB-1:0]        arena, arena_next;
  logic [AB-1:0]        tries, tries_next;
  logic signed [KW-1:0] p, p_next, q, q_next, total, total_next;
  logic signed [KW-1:0] need, need_next, want, want_next, avail, avail_next;
  logic                 res_ok, res_ok_next;
  logic [AB-1:0]        res_arena, res_arena_next;
  logic signed [KW-1:0] res_off, res_off_next;
  logic                 rsp_load;

  logic                 wr_en, rd_en;
  logic [AB-1:0]        rd_arena;
  logic signed [KW-1:0] wr_pos, rd_pos;
  logic [DW-1:0]        wr_data, rd_data;

  logic signed [KW-1:0] h_ext, n_ext, mn;
  logic [15:0]          bytes_sum;
  logic signed [KW-1:0] words_req;
  logic [AB+2:0]        arena_wide;
  logic [AB+2:0]        start_wide;
  logic                 free_bad;

  assign h_ext     = KW'(signed'(rd_data));
  assign n_ext     = ~h_ext;
  assign mn        = KW'(signed'(total[DW-1:0]));
  assign bytes_sum = {1'b0, req.request_bytes} + 16'd7;
  assign words_req = (bytes_sum[15:3] == '0) ? ONE : KW'(bytes_sum[15:3]);
  assign start_wide = (AB+3)'(mfa_pkg::arena_mod(req.start_arena, ARENAS));
  assign arena_wide = (AB+3)'(req.free_arena);
  assign free_bad  = (int'(req.free_arena) >= ARENAS) || (req.free_offset == '0)
                   || (int'(req.free_offset) >= ARENA_WORDS);

  function automatic logic aligned(input logic signed [KW-1:0] w, input logic ph);
    return w[0] == ph;
  endfunction

  mfa_heap_ram #(
    .ARENAS(ARENAS), .ARENA_WORDS(ARENA_WORDS), .AB(AB), .WB(WB), .DW(DW)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_arena(arena),
    .wr_word (wr_pos[WB-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_arena(rd_arena),
    .rd_word (rd_pos[WB-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      align_phase <= 1'b1;
    end else if (cfg_we) begin
      align_phase <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mfa_pkg::ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    arena     <= arena_next;
    tries     <= tries_next;
    p         <= p_next;
    q         <= q_next;
    total     <= total_next;
    need      <= need_next;
    want      <= want_next;
    avail     <= avail_next;
    res_ok    <= res_ok_next;
    res_arena <= res_arena_next;
    res_off   <= res_off_next;
    if (rsp_load) begin
      rsp_ok     <= res_ok;
      rsp_arena  <= 3'((AB+3)'(res_arena));
      rsp_offset <= res_off[11:0];
    end
  end

  always_comb begin
    state_next     = state;
    arena_next     = arena;
    tries_next     = tries;
    p_next         = p;
    q_next         = q;
    total_next     = total;
    need_next      = need;
    want_next      = want;
    avail_next     = avail;
    res_ok_next    = res_ok;
    res_arena_next = res_arena;
    res_off_next   = res_off;
    rsp_load       = 1'b0;
    wr_en          = 1'b0;
    wr_pos         = p;
    wr_data        = '0;
    rd_en          = 1'b0;
    rd_arena       = arena;
    rd_pos         = p;
    req.ready      = 1'b0;

    unique case (state)
      mfa_pkg::ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          res_ok_next    = 1'b1;
          res_arena_next = '0;
          res_off_next   = '0;
          if (req.mode == mfa_pkg::MODE_ALLOC) begin
            need_next  = words_req;
            arena_next = start_wide[AB-1:0];
            tries_next = '0;
            p_next     = '0;
            rd_en      = 1'b1;
            rd_arena   = start_wide[AB-1:0];
            rd_pos     = '0;
            state_next = mfa_pkg::ST_HDR;
          end else if (free_bad) begin
            state_next = mfa_pkg::ST_DONE;
          end else begin
            arena_next = arena_wide[AB-1:0];
            p_next     = KW'(req.free_offset);
            rd_en      = 1'b1;
            rd_arena   = arena_wide[AB-1:0];
            rd_pos     = KW'(req.free_offset) - ONE;
            state_next = mfa_pkg::ST_F1;
          end
        end
      end

      mfa_pkg::ST_HDR: begin
        if (p > LAST || (h_ext < 0 && p + n_ext > LAST)) begin
          // this arena is exhausted
          if (tries == AB'(ARENAS - 1)) begin
            res_ok_next = 1'b0;
            state_next  = mfa_pkg::ST_DONE;
          end else begin
            arena_next = (arena == AB'(ARENAS - 1)) ? '0 : arena + 1'b1;
            tries_next = tries + 1'b1;
            p_next     = '0;
            rd_en      = 1'b1;
            rd_arena   = arena_next;
            rd_pos     = '0;
          end
        end else if (h_ext < 0) begin
          want_next  = need + KW'(aligned(p, align_phase));
          total_next = n_ext;
          if (LAST <= p + n_ext) begin
            state_next = mfa_pkg::ST_MW;
          end else begin
            q_next     = p + n_ext + ONE;
            rd_en      = 1'b1;
            rd_pos     = q_next;
            state_next = mfa_pkg::ST_MRG;
          end
        end else begin
          p_next = p + h_ext + ONE;
          rd_en  = 1'b1;
          rd_pos = p_next;
        end
      end

      mfa_pkg::ST_MRG: begin
        if (h_ext < 0) begin
          total_next = total + n_ext + ONE;
          if (LAST <= q + n_ext) begin
            state_next = mfa_pkg::ST_MW;
          end else begin
            q_next = q + n_ext + ONE;
            rd_en  = 1'b1;
            rd_pos = q_next;
          end
        end else begin
          state_next = mfa_pkg::ST_MW;
        end
      end

      mfa_pkg::ST_MW: begin
        wr_en      = 1'b1;
        wr_pos     = p;
        wr_data    = ~total[DW-1:0];
        avail_next = mn;
        if (mn >= want) begin
          state_next = mfa_pkg::ST_SPLIT;
        end else begin
          p_next     = p + mn + ONE;
          rd_en      = 1'b1;
          rd_pos     = p_next;
          state_next = mfa_pkg::ST_HDR;
        end
      end

      mfa_pkg::ST_SPLIT: begin
        if (avail != want) begin
          wr_en   = 1'b1;
          wr_pos  = p + want + ONE;
          wr_data = ~DW'(avail - want - ONE);
        end
        state_next = mfa_pkg::ST_HDRW;
      end

      mfa_pkg::ST_HDRW: begin
        wr_en          = 1'b1;
        wr_pos         = p;
        wr_data        = want[DW-1:0];
        res_arena_next = arena;
        if (aligned(p, align_phase)) begin
          state_next = mfa_pkg::ST_PAD;
        end else begin
          res_off_next = p + ONE;
          state_next   = mfa_pkg::ST_DONE;
        end
      end

      mfa_pkg::ST_PAD: begin
        wr_en        = 1'b1;
        wr_pos       = p + ONE;
        wr_data      = '0;
        res_off_next = p + KW'(2);
        state_next   = mfa_pkg::ST_DONE;
      end

      mfa_pkg::ST_F1: begin
        if (h_ext == '0) begin
          // step back over the pad word
          p_next = p - ONE;
          if (p - ONE < ONE) begin
            state_next = mfa_pkg::ST_DONE;
          end else begin
            rd_en      = 1'b1;
            rd_pos     = p - KW'(2);
            state_next = mfa_pkg::ST_F2;
          end
        end else begin
          wr_en      = 1'b1;
          wr_pos     = p - ONE;
          wr_data    = ~rd_data;
          state_next = mfa_pkg::ST_DONE;
        end
      end

      mfa_pkg::ST_F2: begin
        wr_en      = 1'b1;
        wr_pos     = p - ONE;
        wr_data    = ~rd_data;
        state_next = mfa_pkg::ST_DONE;
      end

      mfa_pkg::ST_DONE: begin
        if (!rsp_valid || rsp.ready) begin
          rsp_load   = 1'b1;
          state_next = mfa_pkg::ST_IDLE;
        end
      end

      default: state_next = mfa_pkg::ST_IDLE;
    endcase
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.ok            = rsp_ok;
  assign rsp.result_arena  = rsp_arena;
  assign rsp.result_offset = rsp_offset;

  // a chosen block always covers the aligned request
  a_split_fits: assert property (@(posedge clk) disable iff (rst)
    state == mfa_pkg::ST_SPLIT |-> avail >= want)
    else $error("split of a block too small");

  // a failed allocate reports no location
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_load && !res_ok |-> res_arena == '0 && res_off == '0)
    else $error("failure beat carries a location");

  // every granted payload sits on an aligned word
  a_payload_aligned: assert property (@(posedge clk) disable iff (rst)
    state == mfa_pkg::ST_PAD || (state == mfa_pkg::ST_HDRW && p[0] != align_phase)
    |=> res_off[0] == align_phase)
    else $error("payload not aligned");

  // an accepted beat starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> state != mfa_pkg::ST_IDLE)
    else $error("request beat dropped");

endmodule
